// ===== src/tcw_pkg.sv =====
// shared types, constants and helpers for the text console writer
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS = 60;
   localparam int COL_W = 7;
   localparam int ROW_W = 6;
   localparam int ADDR_W = COL_W + ROW_W;
   localparam int MEM_DEPTH = 2 ** ADDR_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = 1;

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   localparam logic [7:0] SPACE_CODE = 8'h20;
   localparam logic [7:0] COLOR_RESET = 8'h10;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   localparam logic [2:0] OP_PUT_CHAR = 3'd0;
   localparam logic [2:0] OP_NEWLINE = 3'd1;
   localparam logic [2:0] OP_MOVE = 3'd2;
   localparam logic [2:0] OP_CLEAR = 3'd3;
   localparam logic [2:0] OP_PUT_HEX = 3'd4;
   localparam logic [2:0] OP_READ = 3'd5;

   localparam logic REG_TEXT_COLOR = 1'b0;

   typedef struct packed {
      logic [2:0]       opcode;
      logic [7:0]       char_code;
      logic [7:0]       hex_value;
      logic [COL_W-1:0] pos_x;
      logic [ROW_W-1:0] pos_y;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0] cursor_column;
      logic [ROW_W-1:0] cursor_row;
      logic             scrolled;
      logic [7:0]       cell_char;
      logic [7:0]       cell_color;
   } rsp_type;

   typedef enum logic [2:0] {
      K_PUT     = 3'd0,
      K_NEWLINE = 3'd1,
      K_MOVE    = 3'd2,
      K_CLEAR   = 3'd3,
      K_HEX     = 3'd4,
      K_READ    = 3'd5,
      K_NOP     = 3'd6
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [7:0]       ch0;
      logic [7:0]       ch1;
      logic [COL_W-1:0] pos_x;
      logic [ROW_W-1:0] pos_y;
   } cmd_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      logic [7:0] d;
      d = {4'h0, n & NIBBLE_MASK};
      if (n < 4'd10) begin
         return 8'h30 + d;
      end
      return 8'h41 + (d - 8'd10);
   endfunction

endpackage

// ===== src/tcw_front.sv =====
// front end: takes requests, saturates positions, expands hex bytes
module tcw_front import tcw_pkg::*; (
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type         req_data,
   input  logic            queue_full,
   input  back_status_type status,
   output logic            push,
   output cmd_type         push_cmd
);

   always_comb begin
      push_cmd.kind = K_NOP;
      push_cmd.ch0 = req_data.char_code;
      push_cmd.ch1 = 8'h00;
      push_cmd.pos_x = (req_data.pos_x > LAST_COL) ? LAST_COL : req_data.pos_x;
      push_cmd.pos_y = (req_data.pos_y > LAST_ROW) ? LAST_ROW : req_data.pos_y;
      case (req_data.opcode)
         OP_PUT_CHAR: begin
            push_cmd.kind = K_PUT;
         end
         OP_NEWLINE: begin
            push_cmd.kind = K_NEWLINE;
         end
         OP_MOVE: begin
            push_cmd.kind = K_MOVE;
         end
         OP_CLEAR: begin
            push_cmd.kind = K_CLEAR;
         end
         OP_PUT_HEX: begin
            push_cmd.kind = K_HEX;
            push_cmd.ch0 = hex_digit(req_data.hex_value[7:4]);
            push_cmd.ch1 = hex_digit(req_data.hex_value[3:0]);
         end
         OP_READ: begin
            push_cmd.kind = K_READ;
         end
         default: begin
            push_cmd.kind = K_NOP;
         end
      endcase
   end

   assign req_stall = queue_full || status.init_busy;
   assign push = req_valid && !req_stall;

endmodule

// ===== src/tcw_queue.sv =====
// short command queue between the front and back ends
module tcw_queue import tcw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

endmodule

// ===== src/tcw_back.sv =====
// back end: cursor, character and color stores, scroll and clear sweeps, result register
module tcw_back import tcw_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic [7:0]      text_color,
   input  logic            cmd_valid,
   input  cmd_type         cmd,
   output logic            cmd_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data,
   output back_status_type status
);

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_READ   = 6'b000100,
      ST_HEX2   = 6'b001000,
      ST_SCROLL = 6'b010000,
      ST_CLEAR  = 6'b100000
   } back_state_type;

   back_state_type   state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [ROW_W-1:0] base_ff, base_in;
   logic [COL_W-1:0] fill_col_ff, fill_col_in;
   logic [ROW_W-1:0] fill_row_ff, fill_row_in;
   logic [7:0]       fill_color_ff, fill_color_in;
   logic             hex_pend_ff, hex_pend_in;
   logic [7:0]       hex_char_ff, hex_char_in;
   logic             scroll_acc_ff, scroll_acc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [7:0]        char_store_ff [MEM_DEPTH];
   logic [7:0]        color_store_ff [MEM_DEPTH];
   logic [7:0]        rd_char_ff, rd_color_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_char_in, wr_color_in;

   logic              out_free;
   logic              finish;
   logic              fin_scrolled;
   logic [7:0]        fin_char, fin_color;
   logic [7:0]        put_ch;
   logic              at_last_col, at_last_row;
   logic [COL_W-1:0]  put_col;
   logic [ROW_W-1:0]  put_row;
   logic              put_scroll;
   logic [ADDR_W-1:0] cursor_addr;

   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] b,
                                                 input logic [ROW_W-1:0] r);
      logic [ROW_W:0] s;
      s = {1'b0, b} + {1'b0, r};
      if (s >= (ROW_W + 1)'(ROWS)) begin
         s = s - (ROW_W + 1)'(ROWS);
      end
      return s[ROW_W-1:0];
   endfunction

   // shared put-char step
   always_comb begin
      put_ch = (state_ff == ST_HEX2) ? hex_char_ff : cmd.ch0;
      at_last_col = (col_ff == LAST_COL);
      at_last_row = (row_ff == LAST_ROW);
      put_col = at_last_col ? '0 : col_ff + COL_W'(1);
      put_row = (at_last_col && !at_last_row) ? row_ff + ROW_W'(1) : row_ff;
      put_scroll = at_last_col && at_last_row;
      cursor_addr = {phys_row(base_ff, row_ff), col_ff};
      rd_addr = {phys_row(base_ff, cmd.pos_y), cmd.pos_x};
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      col_in = col_ff;
      row_in = row_ff;
      base_in = base_ff;
      fill_col_in = fill_col_ff;
      fill_row_in = fill_row_ff;
      fill_color_in = fill_color_ff;
      hex_pend_in = hex_pend_ff;
      hex_char_in = hex_char_ff;
      scroll_acc_in = scroll_acc_ff;
      mem_we = 1'b0;
      wr_addr = cursor_addr;
      wr_char_in = put_ch;
      wr_color_in = text_color;
      cmd_pop = 1'b0;
      finish = 1'b0;
      fin_scrolled = 1'b0;
      fin_char = 8'h00;
      fin_color = 8'h00;

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_we = 1'b1;
            wr_addr = {fill_row_ff, fill_col_ff};
            wr_char_in = SPACE_CODE;
            wr_color_in = (state_ff == ST_INIT) ? COLOR_RESET : fill_color_ff;
            fill_col_in = fill_col_ff + COL_W'(1);
            if (fill_col_ff == LAST_COL) begin
               fill_col_in = '0;
               fill_row_in = fill_row_ff + ROW_W'(1);
               if (fill_row_ff == LAST_ROW) begin
                  fill_row_in = '0;
                  state_in = ST_IDLE;
                  finish = (state_ff == ST_CLEAR);
               end
            end
         end
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               scroll_acc_in = 1'b0;
               hex_pend_in = 1'b0;
               case (cmd.kind)
                  K_PUT, K_HEX: begin
                     mem_we = 1'b1;
                     col_in = put_col;
                     row_in = put_row;
                     hex_char_in = cmd.ch1;
                     if (put_scroll) begin
                        state_in = ST_SCROLL;
                        fill_col_in = '0;
                        fill_color_in = text_color;
                        scroll_acc_in = 1'b1;
                        hex_pend_in = (cmd.kind == K_HEX);
                     end else if (cmd.kind == K_HEX) begin
                        state_in = ST_HEX2;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  K_NEWLINE: begin
                     col_in = '0;
                     if (at_last_row) begin
                        state_in = ST_SCROLL;
                        fill_col_in = '0;
                        fill_color_in = text_color;
                     end else begin
                        row_in = row_ff + ROW_W'(1);
                        finish = 1'b1;
                     end
                  end
                  K_MOVE: begin
                     col_in = cmd.pos_x;
                     row_in = cmd.pos_y;
                     finish = 1'b1;
                  end
                  K_CLEAR: begin
                     col_in = '0;
                     row_in = '0;
                     fill_col_in = '0;
                     fill_row_in = '0;
                     fill_color_in = text_color;
                     state_in = ST_CLEAR;
                  end
                  K_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            finish = 1'b1;
            fin_char = rd_char_ff;
            fin_color = rd_color_ff;
            state_in = ST_IDLE;
         end
         ST_HEX2: begin
            mem_we = 1'b1;
            col_in = put_col;
            row_in = put_row;
            if (put_scroll) begin
               state_in = ST_SCROLL;
               fill_col_in = '0;
               fill_color_in = text_color;
               scroll_acc_in = 1'b1;
            end else begin
               finish = 1'b1;
               fin_scrolled = scroll_acc_ff;
               state_in = ST_IDLE;
            end
         end
         ST_SCROLL: begin
            // old top row becomes the new bottom row
            mem_we = 1'b1;
            wr_addr = {base_ff, fill_col_ff};
            wr_char_in = SPACE_CODE;
            wr_color_in = fill_color_ff;
            fill_col_in = fill_col_ff + COL_W'(1);
            if (fill_col_ff == LAST_COL) begin
               fill_col_in = '0;
               base_in = (base_ff == LAST_ROW) ? '0 : base_ff + ROW_W'(1);
               if (hex_pend_ff) begin
                  hex_pend_in = 1'b0;
                  state_in = ST_HEX2;
               end else begin
                  finish = 1'b1;
                  fin_scrolled = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);
      rsp_data_in = rsp_data_ff;
      if (finish) begin
         rsp_data_in.cursor_column = col_in;
         rsp_data_in.cursor_row = row_in;
         rsp_data_in.scrolled = fin_scrolled;
         rsp_data_in.cell_char = fin_char;
         rsp_data_in.cell_color = fin_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         col_ff <= '0;
         row_ff <= '0;
         base_ff <= '0;
         fill_col_ff <= '0;
         fill_row_ff <= '0;
         hex_pend_ff <= 1'b0;
         scroll_acc_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff <= col_in;
         row_ff <= row_in;
         base_ff <= base_in;
         fill_col_ff <= fill_col_in;
         fill_row_ff <= fill_row_in;
         hex_pend_ff <= hex_pend_in;
         scroll_acc_ff <= scroll_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_color_ff <= fill_color_in;
      hex_char_ff <= hex_char_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         char_store_ff[wr_addr] <= wr_char_in;
         color_store_ff[wr_addr] <= wr_color_in;
      end
      rd_char_ff <= char_store_ff[rd_addr];
      rd_color_ff <= color_store_ff[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign status.init_busy = (state_ff == ST_INIT);

endmodule

// ===== src/text_console_writer_unit.sv =====
// text console writer top level: csr register, front end, queue, back end
//
//  channel  ports                      handshake              payload
//  request  req_valid/req_stall        valid & !stall         req_data (req_type)
//  response rsp_valid/rsp_stall        valid & !stall         rsp_data (rsp_type)
//  csr      csr_psel/penable/pwrite    psel&penable&pwrite    csr_pwdata[7:0] text color
//
// put char, newline, move and unused codes finish from the idle state; read and hex byte also pass ST_READ or ST_HEX2
// a scroll sweeps the recycled row through ST_SCROLL, one store write per cell
// clear sweeps all ROWS*COLUMNS cells through ST_CLEAR, one store write per cell
// after reset a sweep fills the stores; requests stall until it ends
// a two-entry queue lets requests arrive while the back end sweeps or a response stalls
module text_console_writer_unit import tcw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]      text_color_ff, text_color_in;
   back_status_type status;
   logic            push, queue_full, pop, head_valid;
   cmd_type         push_cmd, head_cmd;

   assign csr_pready = 1'b1;

   always_comb begin
      text_color_in = text_color_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr[2] == REG_TEXT_COLOR) begin
         text_color_in = csr_pwdata[7:0];
      end
      csr_prdata = (csr_paddr[2] == REG_TEXT_COLOR) ? {24'h0, text_color_ff} : 32'h0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= COLOR_RESET;
      end else begin
         text_color_ff <= text_color_in;
      end
   end

   tcw_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .status     (status),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tcw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .text_color (text_color_ff),
      .cmd_valid  (head_valid),
      .cmd        (head_cmd),
      .cmd_pop    (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .status     (status)
   );

`ifndef ASSERT_OFF
   // cursor reported inside the grid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.cursor_column <= LAST_COL) && (rsp_data.cursor_row <= LAST_ROW))
      else $error("cursor outside grid");

   // a scroll always leaves the cursor on the last row
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.scrolled) |-> (rsp_data.cursor_row == LAST_ROW))
      else $error("scroll without cursor on last row");

   // no request taken during the reset sweep
   assert property (@(posedge clock) disable iff (reset)
      status.init_busy |-> req_stall)
      else $error("request accepted during store init");

   // nothing popped from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
`endif

endmodule

// ===== verif/tb_text_console_writer_unit.sv =====
// self-checking testbench for the text console writer: directed and random commands
module tb_text_console_writer_unit;
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam logic [2:0] TEXT_COLOR_ADDR = 3'(4 * int'(REG_TEXT_COLOR));
   localparam int STALL_LIMIT = 20000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int HOLDOFF_AFTER = 1300;
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_PER_PHASE = 510;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // console model state
   logic [7:0] screen_char [0:CELLS-1];
   logic [7:0] screen_color [0:CELLS-1];
   int         cursor_x = 0;
   int         cursor_y = 0;
   logic [7:0] color_shadow = COLOR_RESET;

   req_type command_backlog [$];
   rsp_type due_reports [$];
   int      commands_queued = 0;
   int      commands_taken = 0;
   int      fail_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;

   text_console_writer_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < CELLS; i++) begin
         screen_char[i] = 8'h00;
         screen_color[i] = COLOR_RESET;
      end
   end

   function automatic logic [7:0] hex_glyph(input logic [3:0] n);
      if (n < 4'd10) begin
         return 8'h30 + {4'h0, n};
      end
      return 8'h41 + ({4'h0, n} - 8'd10);
   endfunction

   function automatic bit advance_row();
      cursor_y++;
      if (cursor_y >= ROWS) begin
         cursor_y = ROWS - 1;
         for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen_char[i] = screen_char[i + COLUMNS];
            screen_color[i] = screen_color[i + COLUMNS];
         end
         for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen_char[i] = SPACE_CODE;
            screen_color[i] = color_shadow;
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit put_glyph(input logic [7:0] ch);
      int idx;
      idx = cursor_y * COLUMNS + cursor_x;
      screen_char[idx] = ch;
      screen_color[idx] = color_shadow;
      cursor_x++;
      if (cursor_x >= COLUMNS) begin
         cursor_x = 0;
         return advance_row();
      end
      return 1'b0;
   endfunction

   function automatic rsp_type console_step(input req_type cmd);
      rsp_type res;
      bit      scrolled;
      int      col;
      int      row;
      res = '0;
      scrolled = 1'b0;
      col = (cmd.pos_x > LAST_COL) ? int'(LAST_COL) : int'(cmd.pos_x);
      row = (cmd.pos_y > LAST_ROW) ? int'(LAST_ROW) : int'(cmd.pos_y);
      case (cmd.opcode)
         OP_PUT_CHAR: scrolled = put_glyph(cmd.char_code);
         OP_NEWLINE: begin
            cursor_x = 0;
            scrolled = advance_row();
         end
         OP_MOVE: begin
            cursor_x = col;
            cursor_y = row;
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++) begin
               screen_char[i] = SPACE_CODE;
               screen_color[i] = color_shadow;
            end
            cursor_x = 0;
            cursor_y = 0;
         end
         OP_PUT_HEX: begin
            scrolled = put_glyph(hex_glyph(cmd.hex_value[7:4]));
            if (put_glyph(hex_glyph(cmd.hex_value[3:0]))) begin
               scrolled = 1'b1;
            end
         end
         OP_READ: begin
            res.cell_char = screen_char[row * COLUMNS + col];
            res.cell_color = screen_color[row * COLUMNS + col];
         end
         default: ;
      endcase
      res.cursor_column = COL_W'(cursor_x);
      res.cursor_row = ROW_W'(cursor_y);
      res.scrolled = scrolled;
      return res;
   endfunction

   function automatic req_type random_command();
      req_type cmd;
      int      pick;
      cmd.char_code = 8'($urandom_range(0, 255));
      cmd.hex_value = 8'($urandom_range(0, 255));
      cmd.pos_x = COL_W'($urandom_range(0, 127));
      // lean toward the bottom rows so scrolls stay frequent
      cmd.pos_y = ($urandom_range(0, 1) == 0) ? ROW_W'($urandom_range(0, 63))
                                              : ROW_W'($urandom_range(54, 63));
      pick = $urandom_range(0, 999);
      if (pick < 350) begin
         cmd.opcode = OP_PUT_CHAR;
      end else if (pick < 500) begin
         cmd.opcode = OP_PUT_HEX;
      end else if (pick < 630) begin
         cmd.opcode = OP_NEWLINE;
      end else if (pick < 750) begin
         cmd.opcode = OP_MOVE;
      end else if (pick < 960) begin
         cmd.opcode = OP_READ;
      end else if (pick < 970) begin
         cmd.opcode = OP_CLEAR;
      end else if (pick < 985) begin
         cmd.opcode = OP_SPARE_A;
      end else begin
         cmd.opcode = OP_SPARE_B;
      end
      return cmd;
   endfunction

   task automatic queue_command(input req_type cmd);
      command_backlog.push_back(cmd);
      commands_queued++;
   endtask

   task automatic queue_op(input logic [2:0] op, input logic [7:0] code,
                           input logic [6:0] x, input logic [5:0] y);
      req_type cmd;
      cmd.opcode = op;
      cmd.char_code = code;
      cmd.hex_value = code;
      cmd.pos_x = x;
      cmd.pos_y = y;
      queue_command(cmd);
   endtask

   task automatic wait_idle();
      while (commands_taken != commands_queued || due_reports.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_text_color(input logic [7:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= TEXT_COLOR_ADDR;
      csr_pwdata <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      color_shadow = value;
   endtask

   // request driver
   always @(posedge clock) begin : request_driver
      logic taken;
      logic offer;
      if (!reset) begin
         taken = req_valid && !req_stall;
         if (taken) begin
            due_reports.push_back(console_step(req_data));
            commands_taken++;
         end
         if (!req_valid || taken) begin
            offer = command_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
            if (offer) begin
               req_data <= command_backlog.pop_front();
            end
            req_valid <= offer;
         end
      end
   end

   // response monitor and receiver stall
   always @(posedge clock) begin : response_monitor
      int      responses_seen;
      int      hold_left;
      bit      hold_done;
      logic    stall_next;
      rsp_type want;
      if (reset) begin
         responses_seen = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses_seen++;
            if (due_reports.size() == 0) begin
               $error("response with no command outstanding");
               fail_count++;
            end else begin
               want = due_reports.pop_front();
               if (rsp_data.cursor_column !== want.cursor_column) begin
                  $error("cursor_column: expected %0d, got %0d",
                         want.cursor_column, rsp_data.cursor_column);
                  fail_count++;
               end
               if (rsp_data.cursor_row !== want.cursor_row) begin
                  $error("cursor_row: expected %0d, got %0d",
                         want.cursor_row, rsp_data.cursor_row);
                  fail_count++;
               end
               if (rsp_data.scrolled !== want.scrolled) begin
                  $error("scrolled: expected %0d, got %0d", want.scrolled, rsp_data.scrolled);
                  fail_count++;
               end
               if (rsp_data.cell_char !== want.cell_char) begin
                  $error("cell_char: expected %h, got %h", want.cell_char, rsp_data.cell_char);
                  fail_count++;
               end
               if (rsp_data.cell_color !== want.cell_color) begin
                  $error("cell_color: expected %h, got %h",
                         want.cell_color, rsp_data.cell_color);
                  fail_count++;
               end
            end
         end
         // one long hold-off so the request side backs up
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (!hold_done && responses_seen >= HOLDOFF_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLDOFF_CYCLES;
            stall_next = 1'b1;
         end else begin
            stall_next = $urandom_range(0, 99) < recv_idle_pct;
         end
         rsp_stall <= stall_next;
      end
   end

   // watchdog on cycles without any request or response moving
   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 28;
      recv_idle_pct = 51;

      // reset color, all glyph kinds, reads of cells just written
      queue_op(OP_PUT_CHAR, 8'h41, 7'd0, 6'd0);
      queue_op(OP_READ, 8'h00, 7'd0, 6'd0);
      queue_op(OP_PUT_CHAR, 8'h00, 7'd127, 6'd63);
      queue_op(OP_PUT_CHAR, 8'hFF, 7'd0, 6'd0);
      queue_op(OP_PUT_HEX, 8'h00, 7'd0, 6'd0);
      queue_op(OP_PUT_HEX, 8'hFF, 7'd0, 6'd0);
      queue_op(OP_PUT_HEX, 8'h9A, 7'd0, 6'd0);
      queue_op(OP_READ, 8'h00, 7'd2, 6'd0);
      queue_op(OP_READ, 8'h00, 7'd5, 6'd0);
      queue_op(OP_READ, 8'h00, 7'd8, 6'd0);
      // saturating move then a wrap that scrolls
      queue_op(OP_MOVE, 8'h00, 7'd127, 6'd63);
      queue_op(OP_PUT_CHAR, 8'h78, 7'd0, 6'd0);
      queue_op(OP_CLEAR, 8'h00, 7'd0, 6'd0);
      queue_op(OP_READ, 8'h00, 7'd127, 6'd63);
      queue_op(OP_SPARE_A, 8'hFF, 7'd127, 6'd63);
      queue_op(OP_SPARE_B, 8'hFF, 7'd127, 6'd63);
      queue_op(OP_NEWLINE, 8'h00, 7'd0, 6'd0);
      // hex byte whose second digit wraps and scrolls
      queue_op(OP_MOVE, 8'h00, 7'd78, 6'd59);
      queue_op(OP_PUT_HEX, 8'h3C, 7'd0, 6'd0);
      queue_op(OP_READ, 8'h00, 7'd79, 6'd58);
      queue_op(OP_MOVE, 8'h00, 7'd0, 6'd59);
      queue_op(OP_NEWLINE, 8'h00, 7'd0, 6'd0);
      queue_op(OP_MOVE, 8'h00, 7'd79, 6'd0);
      queue_op(OP_PUT_CHAR, 8'h7E, 7'd0, 6'd0);
      queue_op(OP_READ, 8'h00, 7'd79, 6'd0);
      wait_idle();

      write_text_color(8'hFF);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
         queue_command(random_command());
      end
      wait_idle();

      send_idle_pct = 51;
      recv_idle_pct = 28;
      write_text_color(8'h00);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
         queue_command(random_command());
      end
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_text_color(8'($urandom_range(1, 254)));
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
         queue_command(random_command());
      end
      wait_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && due_reports.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
